// File: design/ole_pkg.sv
`timescale 1ns / 1ps

package ole_pkg;

	localparam int FUNC_W = 3;
	localparam int POS_W = 6;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int ACT_W = 3;

	localparam int MAX_DUMP = 32;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPW = $clog2(QUEUE_DEPTH);

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [STAT_W-1:0] stat_t;
	typedef logic [ACT_W-1:0] act_t;

	localparam func_t FN_APPEND = 3'd0;
	localparam func_t FN_INS_HEAD = 3'd1;
	localparam func_t FN_INS_POS = 3'd2;
	localparam func_t FN_DEL_HEAD = 3'd3;
	localparam func_t FN_DEL_TAIL = 3'd4;
	localparam func_t FN_DEL_POS = 3'd5;
	localparam func_t FN_SEARCH = 3'd6;
	localparam func_t FN_DUMP = 3'd7;

	localparam stat_t STAT_OK = 2'd0;
	localparam stat_t STAT_FULL = 2'd1;
	localparam stat_t STAT_EMPTY = 2'd2;
	localparam stat_t STAT_RANGE = 2'd3;

	localparam act_t ACT_REPLY = 3'd0;
	localparam act_t ACT_INSERT = 3'd1;
	localparam act_t ACT_DELETE = 3'd2;
	localparam act_t ACT_SEARCH = 3'd3;
	localparam act_t ACT_DUMP = 3'd4;

	typedef struct packed {
		act_t  action;
		stat_t status;
		pos_t  slot;
		data_t value;
	} cmd_t;

endpackage

// File: design/ole_if.sv
`timescale 1ns / 1ps

interface ole_in_if import ole_pkg::*; ();
	logic  valid;
	logic  ready;
	func_t func;
	data_t value;
	pos_t  position;

	modport source (output valid, output func, output value, output position, input ready);
	modport sink (input valid, input func, input value, input position, output ready);
endinterface

interface ole_out_if import ole_pkg::*; ();
	logic  valid;
	logic  ready;
	stat_t status;
	logic  found;
	pos_t  index;
	data_t data;
	logic  last;

	modport source (output valid, output status, output found, output index, output data,
		output last, input ready);
	modport sink (input valid, input status, input found, input index, input data,
		input last, output ready);
endinterface

// File: design/ole_front.sv
`timescale 1ns / 1ps

module ole_front import ole_pkg::*; #(
	parameter int LIST_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ole_in_if.sink     req,
	input  logic       q_full,
	output logic       push,
	output cmd_t       cmd
);

	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          list_full;
	logic          list_empty;
	logic          ins_pos_ok;
	logic          del_pos_ok;
	logic          grow;
	logic          shrink;

	assign list_full = (int'(count_q) == LIST_DEPTH);
	assign list_empty = (count_q == '0);
	assign ins_pos_ok = (req.position != '0) && (int'(req.position) <= int'(count_q) + 1);
	assign del_pos_ok = (req.position != '0) && (int'(req.position) <= int'(count_q));

	assign req.ready = !q_full;
	assign push = req.valid && !q_full;

	always_comb begin
		cmd.action = ACT_REPLY;
		cmd.status = STAT_OK;
		cmd.slot = '0;
		cmd.value = req.value;
		grow = 1'b0;
		shrink = 1'b0;
		unique case (req.func)
			FN_APPEND, FN_INS_HEAD, FN_INS_POS: begin
				if (list_full) begin
					cmd.status = STAT_FULL;
				end else if (req.func == FN_APPEND) begin
					cmd.action = ACT_INSERT;
					cmd.slot = POS_W'(count_q);
					grow = 1'b1;
				end else if (req.func == FN_INS_HEAD) begin
					cmd.action = ACT_INSERT;
					grow = 1'b1;
				end else if (!ins_pos_ok) begin
					cmd.status = STAT_RANGE;
				end else begin
					cmd.action = ACT_INSERT;
					cmd.slot = req.position - POS_W'(1);
					grow = 1'b1;
				end
			end
			FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS: begin
				if (list_empty) begin
					cmd.status = STAT_EMPTY;
				end else if (req.func == FN_DEL_HEAD) begin
					cmd.action = ACT_DELETE;
					shrink = 1'b1;
				end else if (req.func == FN_DEL_TAIL) begin
					cmd.action = ACT_DELETE;
					cmd.slot = POS_W'(count_q - CW'(1));
					shrink = 1'b1;
				end else if (!del_pos_ok) begin
					cmd.status = STAT_RANGE;
				end else begin
					cmd.action = ACT_DELETE;
					cmd.slot = req.position - POS_W'(1);
					shrink = 1'b1;
				end
			end
			FN_SEARCH: begin
				cmd.action = ACT_SEARCH;
			end
			FN_DUMP: begin
				if (list_empty) begin
					cmd.status = STAT_EMPTY;
				end else begin
					cmd.action = ACT_DUMP;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (grow) begin
				count_q <= count_q + CW'(1);
			end else if (shrink) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: design/ole_queue.sv
`timescale 1ns / 1ps

module ole_queue import ole_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	cmd_t           mem_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QPW:0]   fill_q;

	assign full = (fill_q == (QPW + 1)'(QUEUE_DEPTH));
	assign valid = (fill_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPW + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

// File: design/ole_back.sv
`timescale 1ns / 1ps

module ole_back import ole_pkg::*; #(
	parameter int LIST_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       cmd,
	output logic       pop,
	ole_out_if.source  rsp
);

	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int IW = $clog2(LIST_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_FIND = 2'd1;
	localparam logic [1:0] S_DUMP = 2'd2;

	data_t                 cell_q [LIST_DEPTH];
	logic [CW-1:0]         count_q;
	logic [1:0]            state_q;
	logic [1:0]            state_d;
	logic [LIST_DEPTH-1:0] hit_q;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         slot;
	logic [IW-1:0]         first;
	logic [IW:0]           first_pos;
	logic [IW:0]           idx_pos;
	logic                  dump_last;
	logic                  out_free;
	logic                  emit;
	stat_t                 e_status;
	logic                  e_found;
	pos_t                  e_index;
	data_t                 e_data;
	logic                  e_last;

	logic                  out_valid_q;
	stat_t                 out_status_q;
	logic                  out_found_q;
	pos_t                  out_index_q;
	data_t                 out_data_q;
	logic                  out_last_q;

	assign slot = cmd.slot[IW-1:0];
	assign out_free = !out_valid_q || rsp.ready;
	assign pop = (state_q == S_IDLE) && q_valid && out_free;

	assign idx_pos = {1'b0, idx_q} + (IW + 1)'(1);
	assign dump_last = (int'(idx_pos) == int'(count_q)) || (int'(idx_pos) == MAX_DUMP);

	always_comb begin
		first = '0;
		for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
			if (hit_q[i]) begin
				first = IW'(i);
			end
		end
	end

	assign first_pos = {1'b0, first} + (IW + 1)'(1);

	always_comb begin
		emit = 1'b0;
		e_status = STAT_OK;
		e_found = 1'b0;
		e_index = '0;
		e_data = '0;
		e_last = 1'b1;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					if (cmd.action == ACT_SEARCH) begin
						state_d = S_FIND;
					end else if (cmd.action == ACT_DUMP) begin
						state_d = S_DUMP;
					end else begin
						emit = 1'b1;
						e_status = cmd.status;
						if (cmd.action == ACT_DELETE) begin
							e_data = cell_q[slot];
						end
					end
				end
			end
			S_FIND: begin
				if (out_free) begin
					emit = 1'b1;
					e_found = |hit_q;
					e_index = (|hit_q) ? POS_W'(first_pos) : '0;
					state_d = S_IDLE;
				end
			end
			S_DUMP: begin
				if (out_free) begin
					emit = 1'b1;
					e_index = POS_W'(idx_pos);
					e_data = cell_q[idx_q];
					e_last = dump_last;
					if (dump_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && cmd.action == ACT_INSERT) begin
				count_q <= count_q + CW'(1);
			end else if (pop && cmd.action == ACT_DELETE) begin
				count_q <= count_q - CW'(1);
			end
			if (pop && cmd.action == ACT_DUMP) begin
				idx_q <= '0;
			end else if (state_q == S_DUMP && out_free && !dump_last) begin
				idx_q <= idx_q + IW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.action == ACT_INSERT) begin
			for (int i = 1; i < LIST_DEPTH; i++) begin
				if (i > int'(slot)) begin
					cell_q[i] <= cell_q[i-1];
				end
			end
			cell_q[slot] <= cmd.value;
		end else if (pop && cmd.action == ACT_DELETE) begin
			for (int i = 0; i < LIST_DEPTH - 1; i++) begin
				if (i >= int'(slot)) begin
					cell_q[i] <= cell_q[i+1];
				end
			end
		end
		if (pop && cmd.action == ACT_SEARCH) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				hit_q[i] <= (cell_q[i] == cmd.value) && (i < int'(count_q));
			end
		end
		if (emit) begin
			out_status_q <= e_status;
			out_found_q <= e_found;
			out_index_q <= e_index;
			out_data_q <= e_data;
			out_last_q <= e_last;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.found = out_found_q;
	assign rsp.index = out_index_q;
	assign rsp.data = out_data_q;
	assign rsp.last = out_last_q;

endmodule

// File: design/ordered_list_engine.sv
// Accepted items enter a four-entry command queue; an input transfer is taken whenever it has room.
// Edits and error replies go through the queue and output register; one per cycle unless stalled.
// Search: the back end is busy while it compares into hit flags, then encodes the first hit.
// Dump of n entries: one result per cycle unless the output stalls; back end busy until the last.
// Reset clears the entry count and control state; entries are undefined until written.
`timescale 1ns / 1ps

module ordered_list_engine import ole_pkg::*; #(
	parameter int LIST_DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	ole_in_if.sink    req,
	ole_out_if.source rsp
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_valid;
	cmd_t q_head;
	logic pop;

	ole_front #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	ole_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	ole_back #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.cmd     (q_head),
		.pop     (pop),
		.rsp     (rsp)
	);

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> q_valid)
		else $error("accepted transfer did not reach the command queue");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STAT_OK |-> rsp.last && rsp.data == '0)
		else $error("error result is not a single closing result");

	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> rsp.status == STAT_OK && rsp.last && rsp.data == '0)
		else $error("search hit carries wrong fields");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ole_pkg::*;

	localparam int DEPTH = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_TAIL = 15;

	typedef struct {
		func_t func;
		data_t value;
		pos_t  position;
		bit    hold;
	} list_op_t;

	typedef struct {
		stat_t status;
		logic  found;
		pos_t  index;
		data_t data;
		logic  last;
	} list_reply_t;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} op_mix_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ole_in_if  req ();
	ole_out_if rsp ();

	ordered_list_engine #(
		.LIST_DEPTH(DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	list_op_t    pending_q[$];
	list_reply_t reply_q[$];

	data_t list_mem [DEPTH];
	int    list_len = 0;

	int gen_len = 0;
	int full_hits = 0;
	int empty_hits = 0;

	int  errors = 0;
	int  ops_done = 0;
	int  cycles = 0;
	bit  took = 1'b0;

	int burst_left = 0;
	int gap_left = 0;

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_mode_left = 0;
	int       rx_phase = 0;
	int       stall_left = 0;
	bit       long_stall_done = 1'b0;

	task automatic report(input string msg);
		errors++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic void insert_at(input int slot, input data_t v);
		for (int i = list_len; i > slot; i--)
			list_mem[i] = list_mem[i-1];
		list_mem[slot] = v;
		list_len++;
	endfunction

	function automatic data_t remove_at(input int slot);
		data_t v;
		v = list_mem[slot];
		for (int i = slot; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i+1];
		list_len--;
		return v;
	endfunction

	task automatic apply_op(input list_op_t op);
		list_reply_t r;
		int p;
		int n;
		r = '{STAT_OK, 1'b0, '0, '0, 1'b1};
		p = op.position;
		case (op.func)
			FN_APPEND, FN_INS_HEAD, FN_INS_POS: begin
				if (list_len >= DEPTH)
					r.status = STAT_FULL;
				else if (op.func == FN_APPEND)
					insert_at(list_len, op.value);
				else if (op.func == FN_INS_HEAD)
					insert_at(0, op.value);
				else if (p < 1 || p > list_len + 1)
					r.status = STAT_RANGE;
				else
					insert_at(p - 1, op.value);
				reply_q.push_back(r);
			end
			FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS: begin
				if (list_len == 0)
					r.status = STAT_EMPTY;
				else if (op.func == FN_DEL_HEAD)
					r.data = remove_at(0);
				else if (op.func == FN_DEL_TAIL)
					r.data = remove_at(list_len - 1);
				else if (p < 1 || p > list_len)
					r.status = STAT_RANGE;
				else
					r.data = remove_at(p - 1);
				reply_q.push_back(r);
			end
			FN_SEARCH: begin
				for (int i = 0; i < list_len; i++) begin
					if (!r.found && list_mem[i] == op.value) begin
						r.found = 1'b1;
						r.index = pos_t'(i + 1);
					end
				end
				reply_q.push_back(r);
			end
			default: begin
				if (list_len == 0) begin
					r.status = STAT_EMPTY;
					reply_q.push_back(r);
				end else begin
					n = (list_len < MAX_DUMP) ? list_len : MAX_DUMP;
					for (int i = 0; i < n; i++) begin
						r.index = pos_t'(i + 1);
						r.data = list_mem[i];
						r.last = (i == n - 1);
						reply_q.push_back(r);
					end
				end
			end
		endcase
	endtask

	task automatic check_reply();
		list_reply_t exp;
		list_reply_t got;
		got = '{rsp.status, rsp.found, rsp.index, rsp.data, rsp.last};
		if (reply_q.size() == 0) begin
			report($sformatf("result with nothing pending: status %0d index %0d data %0d",
				got.status, got.index, got.data));
		end else begin
			exp = reply_q.pop_front();
			if (exp.status !== got.status)
				report($sformatf("status: expected %0d, got %0d", exp.status, got.status));
			if (exp.found !== got.found)
				report($sformatf("found: expected %0d, got %0d", exp.found, got.found));
			if (exp.index !== got.index)
				report($sformatf("index: expected %0d, got %0d", exp.index, got.index));
			if (exp.data !== got.data)
				report($sformatf("data: expected %0d, got %0d", exp.data, got.data));
			if (exp.last !== got.last)
				report($sformatf("last: expected %0d, got %0d", exp.last, got.last));
		end
	endtask

	task automatic add_op(input func_t f, input data_t v, input int p, input bit h);
		list_op_t op;
		op = '{f, v, pos_t'(p), h};
		pending_q.push_back(op);
		case (f)
			FN_APPEND, FN_INS_HEAD, FN_INS_POS: begin
				if (gen_len >= DEPTH)
					full_hits++;
				else if (f != FN_INS_POS || (p >= 1 && p <= gen_len + 1))
					gen_len++;
			end
			FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS: begin
				if (gen_len == 0)
					empty_hits++;
				else if (f != FN_DEL_POS || (p >= 1 && p <= gen_len))
					gen_len--;
			end
			FN_DUMP: begin
				if (gen_len == 0)
					empty_hits++;
			end
			default: ;
		endcase
	endtask

	function automatic data_t pick_value();
		if ($urandom_range(0, 1) == 0)
			return data_t'($signed($urandom_range(0, 7)) - 3);
		return data_t'($urandom);
	endfunction

	function automatic int pick_pos(input bit for_insert);
		int hi;
		hi = for_insert ? gen_len + 1 : gen_len;
		if (hi < 1 || $urandom_range(0, 4) == 0)
			return $urandom_range(0, 63);
		return $urandom_range(1, hi);
	endfunction

	task automatic add_random_op(input op_mix_t mix, input bit h);
		int roll;
		func_t f;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:
				f = (roll < 90) ? func_t'($urandom_range(FN_APPEND, FN_INS_POS)) :
					(roll < 95) ? FN_SEARCH :
					(roll < 97) ? FN_DUMP :
					func_t'($urandom_range(FN_DEL_HEAD, FN_DEL_POS));
			MIX_DRAIN:
				f = (roll < 90) ? func_t'($urandom_range(FN_DEL_HEAD, FN_DEL_POS)) :
					(roll < 95) ? FN_SEARCH :
					(roll < 97) ? FN_DUMP :
					func_t'($urandom_range(FN_APPEND, FN_INS_POS));
			default:
				f = func_t'($urandom_range(0, 7));
		endcase
		add_op(f, pick_value(), pick_pos(f <= FN_INS_POS), h);
	endtask

	// acceptance, prediction and result checking
	always @(posedge clk) begin
		took = arst_n && req.valid && req.ready;
		if (arst_n && rsp.valid && rsp.ready)
			check_reply();
		if (took) begin
			apply_op(pending_q[0]);
			void'(pending_q.pop_front());
			ops_done++;
		end
	end

	// sender: bursts with gaps; hold a marked item until all results are back
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.func <= FN_APPEND;
			req.value <= '0;
			req.position <= '0;
		end else if (req.valid && !took) begin
		end else if (gap_left != 0) begin
			req.valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_q.size() == 0 || (pending_q[0].hold && reply_q.size() != 0)) begin
			req.valid <= 1'b0;
		end else begin
			req.valid <= 1'b1;
			req.func <= pending_q[0].func;
			req.value <= pending_q[0].value;
			req.position <= pending_q[0].position;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 16);
				gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end else begin
				burst_left <= burst_left - 1;
			end
		end
	end

	// receiver: stall pattern of its own, plus one long hold-off
	always @(negedge clk) begin
		rx_phase <= rx_phase + 1;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (stall_left != 0) begin
			rsp.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!long_stall_done && ops_done >= 40) begin
			rsp.ready <= 1'b0;
			stall_left <= 150;
			long_stall_done <= 1'b1;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_mode_left <= $urandom_range(20, 80);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   rsp.ready <= 1'b1;
				RX_COIN:   rsp.ready <= $urandom_range(0, 1);
				RX_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
				default:   rsp.ready <= (rx_phase % 3 != 0);
			endcase
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int start_hits;
		int guard;

		add_op(FN_DEL_HEAD, 0, 0, 1'b0);
		add_op(FN_DEL_TAIL, 0, 0, 1'b0);
		add_op(FN_DEL_POS, 0, 1, 1'b0);
		add_op(FN_DUMP, 0, 0, 1'b0);
		add_op(FN_SEARCH, 0, 0, 1'b0);
		add_op(FN_INS_POS, 7, 0, 1'b0);
		add_op(FN_INS_POS, 7, 2, 1'b0);
		add_op(FN_INS_POS, 32'sh8000_0000, 1, 1'b0);
		add_op(FN_APPEND, 32'sh7fff_ffff, 0, 1'b0);
		add_op(FN_INS_HEAD, -1, 0, 1'b0);
		add_op(FN_INS_POS, 5, 4, 1'b0);
		add_op(FN_INS_POS, -1, 2, 1'b0);
		add_op(FN_SEARCH, -1, 0, 1'b0);
		add_op(FN_SEARCH, 32'sh7fff_ffff, 0, 1'b0);
		add_op(FN_SEARCH, 12345, 0, 1'b0);
		add_op(FN_DEL_POS, 0, 0, 1'b0);
		add_op(FN_DEL_POS, 0, 63, 1'b0);
		add_op(FN_DEL_POS, 0, 6, 1'b0);
		add_op(FN_DUMP, 0, 0, 1'b0);
		add_op(FN_DEL_POS, 0, 3, 1'b0);
		add_op(FN_DEL_TAIL, 0, 0, 1'b0);
		add_op(FN_DEL_HEAD, 0, 0, 1'b0);
		add_op(FN_DEL_POS, 0, 2, 1'b0);
		add_op(FN_INS_POS, 9, 63, 1'b0);
		add_op(FN_DUMP, 0, 0, 1'b0);

		start_hits = full_hits;
		guard = 0;
		while (full_hits < start_hits + 3 && guard < 300) begin
			add_random_op(MIX_FILL, 1'b0);
			guard++;
		end
		start_hits = empty_hits;
		guard = 0;
		while (empty_hits < start_hits + 3 && guard < 300) begin
			add_random_op(MIX_DRAIN, guard == 0);
			guard++;
		end
		for (int i = 0; i < RANDOM_TAIL; i++)
			add_random_op(MIX_ANY, i == 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || reply_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
